>>> hw/rtl/bhtd_pkg.sv
// Shared types and constants for the bucketed hash table.
package bhtd_pkg;

  localparam int KEY_W       = 64;
  localparam int DEPTH_W     = 8;
  localparam int SCORE_W     = 16;
  localparam int FLAG_W      = 2;
  localparam int MOVE_W      = 16;
  localparam int KIND_W      = 2;
  localparam int IDX_BITS_W  = 4;
  localparam int KEY_IDX_W   = 15;
  localparam int RECIP_SHIFT = 31;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 4;
  localparam int IN_DATA_W   = 112;
  localparam int OUT_DATA_W  = 48;
  localparam int OUT_USER_W  = 1;

  localparam logic [IDX_BITS_W-1:0] IDX_BITS_RESET   = 4'd10;
  localparam logic [FLAG_W-1:0]     EXACT_FLAG_RESET = 2'd0;

  localparam logic [CFG_ADDR_W-1:0] CFG_INDEX_BITS = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_EXACT_FLAG = 2'd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_PROBE = 2'd0,
    KIND_STORE = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NOP   = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_QUOT,
    ST_PROD,
    ST_SUB,
    ST_FOLD,
    ST_BASE,
    ST_RD,
    ST_EV,
    ST_WRITE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic signed [DEPTH_W-1:0] depth;
    logic signed [SCORE_W-1:0] score;
    logic [FLAG_W-1:0]         flag;
    logic [MOVE_W-1:0]         move;
  } payload_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    payload_t         payload;
  } entry_t;

endpackage

>>> hw/rtl/bucketed_hash_table_depth_replace.sv
// Top level of the depth-preferred set-associative hash table.
//
//   channel  direction  signals                               payload
//   s_*      in         s_tvalid s_tready s_tdata s_tuser     one request
//   m_*      out        m_tvalid m_tready m_tdata m_tuser     one result per request
//   cfg_*    in         cfg_valid cfg_ready cfg_addr cfg_data register write
//
// A probe or store forms the bucket address (reciprocal multiply, back-multiply, subtract,
// one fold, base), then reads and compares one way at a time. A probe stops at the first
// hit and a store at a matching entry that it keeps; a store that writes ends in a write
// state. The next request can be taken in the same cycle as its result becomes valid.
// A clear sweeps all NUM_BUCKETS*WAYS entries, one per cycle (4096 by default).
// After reset the same sweep runs before the first request is taken.
// A finished result waits in the output register while the next request is taken.
module bucketed_hash_table_depth_replace #(
  parameter int NUM_BUCKETS = 1024,
  parameter int WAYS        = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // lookup_key, new_depth, new_score, new_flag, new_move, zero fill
  input  logic [bhtd_pkg::IN_DATA_W-1:0]      s_tdata,
  // kind
  input  logic [bhtd_pkg::KIND_W-1:0]         s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // found_depth, found_score, found_flag, found_move, written, zero fill
  output logic [bhtd_pkg::OUT_DATA_W-1:0]     m_tdata,
  // hit
  output logic [bhtd_pkg::OUT_USER_W-1:0]     m_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bhtd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [bhtd_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import bhtd_pkg::*;

  localparam int ENTRIES = NUM_BUCKETS * WAYS;
  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int WW      = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int BKW     = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int ALU_W   = (KEY_IDX_W + 3 > DEPTH_W + 1) ? KEY_IDX_W + 3 : DEPTH_W + 1;
  localparam int RECIP_W = RECIP_SHIFT + 1;
  localparam int PROD_W  = KEY_IDX_W + RECIP_W;
  localparam int QN_W    = KEY_IDX_W + 17;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / NUM_BUCKETS);

  state_t state;
  state_t state_next;

  logic [IDX_BITS_W-1:0]     index_bits;
  logic [FLAG_W-1:0]         exact_flag;
  kind_t                     kind;
  logic [KEY_W-1:0]          key;
  payload_t                  new_entry;
  logic [KEY_IDX_W-1:0]      quot;
  logic [KEY_IDX_W-1:0]      qn;
  logic [KEY_IDX_W-1:0]      rem;
  logic [BKW-1:0]            r;
  logic [AW-1:0]             base;
  logic [WW-1:0]             way;
  logic                      have;
  logic [WW-1:0]             target;
  logic [WW-1:0]             sh_idx;
  logic signed [DEPTH_W-1:0] sh_depth;
  logic [AW-1:0]             clr_addr;
  logic                      res_hit;
  payload_t                  res_payload;
  logic                      res_written;
  logic [OUT_DATA_W-1:0]     out_data;
  logic                      out_hit;

  logic [KEY_IDX_W:0]        mask_full;
  logic [KEY_IDX_W-1:0]      mkey;
  logic [PROD_W-1:0]         quot_prod;
  logic [QN_W-1:0]           qn_prod;
  logic signed [ALU_W-1:0]   alu_a;
  logic signed [ALU_W-1:0]   alu_b;
  logic [ALU_W-1:0]          alu_diff;
  logic                      alu_ge;
  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  entry_t                    mem_wdata;
  logic [AW-1:0]             mem_raddr;
  entry_t                    mem_rdata;
  logic                      key_eq;
  logic                      last_way;
  logic                      last_clr;
  logic                      keep_old;
  logic [WW-1:0]             target_final;
  logic                      out_free;

  assign cfg_ready = 1'b1;
  assign m_tdata   = out_data;
  assign m_tuser   = out_hit;

  assign mask_full    = (16'd1 << index_bits) - 16'd1;
  assign mkey         = key[KEY_IDX_W-1:0] & mask_full[KEY_IDX_W-1:0];
  assign quot_prod    = PROD_W'(mkey) * PROD_W'(RECIP);
  assign qn_prod      = QN_W'(quot) * QN_W'(NUM_BUCKETS);
  assign key_eq       = (mem_rdata.key == key);
  assign last_way     = (way == WW'(WAYS - 1));
  assign last_clr     = (clr_addr == AW'(ENTRIES - 1));
  assign keep_old     = !alu_ge && (new_entry.flag != exact_flag);
  assign target_final = have ? target : sh_idx;
  assign out_free     = !m_tvalid || m_tready;

  bhtd_alu #(.W(ALU_W)) u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .diff (alu_diff),
    .ge   (alu_ge)
  );

  bhtd_mem #(.DEPTH(ENTRIES), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT: begin
        if (last_clr) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          unique case (kind_t'(s_tuser)) inside
            KIND_PROBE, KIND_STORE: state_next = ST_QUOT;
            KIND_CLEAR:             state_next = ST_CLEAR;
            default:                state_next = ST_DONE;
          endcase
        end
      end
      ST_CLEAR: begin
        if (last_clr) state_next = ST_DONE;
      end
      ST_QUOT: state_next = ST_PROD;
      ST_PROD: state_next = ST_SUB;
      ST_SUB:  state_next = ST_FOLD;
      ST_FOLD: state_next = ST_BASE;
      ST_BASE: state_next = ST_RD;
      ST_RD:   state_next = ST_EV;
      ST_EV: begin
        if (kind == KIND_PROBE) begin
          state_next = (key_eq || last_way) ? ST_DONE : ST_RD;
        end else if (key_eq) begin
          state_next = keep_old ? ST_DONE : ST_WRITE;
        end else begin
          state_next = last_way ? ST_WRITE : ST_RD;
        end
      end
      ST_WRITE: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_INIT;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = '0;
    mem_raddr = base + AW'(way);
    alu_a     = ALU_W'(mkey);
    alu_b     = ALU_W'(qn);
    unique case (state) inside
      ST_IDLE: s_tready = 1'b1;
      ST_INIT, ST_CLEAR: mem_we = 1'b1;
      ST_FOLD: begin
        alu_a = ALU_W'(rem);
        alu_b = ALU_W'(NUM_BUCKETS);
      end
      ST_EV: begin
        if (key_eq) begin
          alu_a = ALU_W'(new_entry.depth);
          alu_b = ALU_W'(mem_rdata.payload.depth);
        end else begin
          alu_a = ALU_W'(mem_rdata.payload.depth);
          alu_b = ALU_W'(sh_depth);
        end
      end
      ST_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = base + AW'(target_final);
        mem_wdata = {key, new_entry};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      index_bits <= IDX_BITS_RESET;
      exact_flag <= EXACT_FLAG_RESET;
      clr_addr   <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        unique case (cfg_addr)
          CFG_INDEX_BITS: index_bits <= cfg_data;
          CFG_EXACT_FLAG: exact_flag <= cfg_data[FLAG_W-1:0];
          default: ;
        endcase
      end
      if (state == ST_INIT || state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end else begin
        clr_addr <= '0;
      end
      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        kind            <= kind_t'(s_tuser);
        key             <= s_tdata[63:0];
        new_entry.depth <= s_tdata[71:64];
        new_entry.score <= s_tdata[87:72];
        new_entry.flag  <= s_tdata[89:88];
        new_entry.move  <= s_tdata[105:90];
        way             <= '0;
        have            <= 1'b0;
        res_hit         <= 1'b0;
        res_payload     <= '0;
        res_written     <= 1'b0;
      end
      ST_QUOT: quot <= quot_prod[PROD_W-2:RECIP_SHIFT];
      ST_PROD: qn   <= qn_prod[KEY_IDX_W-1:0];
      ST_SUB:  rem  <= alu_diff[KEY_IDX_W-1:0];
      ST_FOLD: r    <= alu_ge ? BKW'(alu_diff) : BKW'(rem);
      ST_BASE: base <= AW'(r) * AW'(WAYS);
      ST_EV: begin
        way <= way + 1'b1;
        if (kind == KIND_PROBE) begin
          if (key_eq) begin
            res_hit     <= 1'b1;
            res_payload <= mem_rdata.payload;
          end
        end else if (key_eq) begin
          have   <= 1'b1;
          target <= way;
        end else begin
          if (mem_rdata.key == '0 && !have) begin
            have   <= 1'b1;
            target <= way;
          end
          if (way == '0 || !alu_ge) begin
            sh_idx   <= way;
            sh_depth <= mem_rdata.payload.depth;
          end
        end
      end
      ST_WRITE: res_written <= 1'b1;
      ST_DONE: begin
        if (out_free) begin
          out_hit  <= res_hit;
          out_data <= {5'b0, res_written, res_payload.move, res_payload.flag,
                       res_payload.score, res_payload.depth};
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  a_reset_sweep: assert property (@(posedge clk) rst |=> state == ST_INIT)
    else $error("Reset did not start the clearing sweep.");
  a_write_state: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_WRITE || state == ST_INIT || state == ST_CLEAR))
    else $error("Memory written outside a write or sweep state.");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("A second request was taken while one was in work.");
  a_hit_xor_write: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(out_hit && out_data[42]))
    else $error("A result reports both a hit and a write.");
  a_bucket_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_BASE |-> r < NUM_BUCKETS)
    else $error("Bucket index out of range after reduction.");
`endif

endmodule

>>> hw/rtl/bhtd_alu.sv
// Shared subtract and signed compare unit used by the sequencer.
module bhtd_alu #(
  parameter int W = 18
) (
  input  logic signed [W-1:0] a,
  input  logic signed [W-1:0] b,
  output logic        [W-1:0] diff,
  output logic                ge
);

  assign diff = a - b;
  assign ge   = (a >= b);

endmodule

>>> hw/rtl/bhtd_mem.sv
// Entry memory: one write port and one registered read port.
module bhtd_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  bhtd_pkg::entry_t wdata,
  input  logic [AW-1:0]    raddr,
  output bhtd_pkg::entry_t rdata
);
  import bhtd_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
